// ===== rtl/pgbs_pkg.sv =====
package pgbs_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int CRD_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 8;
  localparam int GEO_W = 4 * CRD_W;
  localparam int KEY_W = CLASS_W + SCORE_W;
  localparam int DATA_W = GEO_W + KEY_W;
  localparam logic [15:0] THR_RESET = 16'd29491;
  localparam int IOU_LAT = 6;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_START,
    ST_SORT_NEW,
    ST_SORT_STEP,
    ST_SORT_CMP,
    ST_SUP_START,
    ST_SUP_A,
    ST_SUP_AG,
    ST_SUP_K,
    ST_SUP_B,
    ST_SUP_BG,
    ST_SUP_WAIT,
    ST_SUP_KEEP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic done;
    logic hit;
  } iou_res_t;

  function automatic logic ranks_before(logic [KEY_W-1:0] x, logic [KEY_W-1:0] y);
    logic [CLASS_W-1:0] cx_v;
    logic [CLASS_W-1:0] cy_v;
    cx_v = x[KEY_W-1:SCORE_W];
    cy_v = y[KEY_W-1:SCORE_W];
    if (cx_v != cy_v) begin
      return cx_v < cy_v;
    end
    return x[SCORE_W-1:0] > y[SCORE_W-1:0];
  endfunction

endpackage

// ===== rtl/pgbs_ram.sv =====
module pgbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pgbs_iou.sv =====
module pgbs_iou (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pgbs_pkg::GEO_W-1:0] geo_a,
  input  logic [pgbs_pkg::GEO_W-1:0] geo_b,
  input  logic [15:0]               thr,
  output pgbs_pkg::iou_res_t        res
);
  import pgbs_pkg::*;

  logic [IOU_LAT-1:0] vld_r;
  logic signed [18:0] l1, r1, t1, d1, l2, r2, t2, d2;
  logic signed [18:0] il_r, ir_r, it_r, id_r;
  logic [31:0] aa_r, ab_r;
  logic ok_r, ok2_r, ok3_r, ok4_r, hit_r;
  logic [16:0] iw_r, ih_r;
  logic [32:0] asum_r, asum2_r;
  logic [33:0] inter_r, inter3_r, inter4_r;
  logic [34:0] uni_r;
  logic [50:0] prod_r;
  logic signed [18:0] iw_s, ih_s;

  function automatic logic signed [18:0] dbl(logic [15:0] v);
    return signed'({2'b00, v, 1'b0});
  endfunction

  function automatic logic signed [18:0] ext(logic [15:0] v);
    return signed'({3'b000, v});
  endfunction

  always_comb begin
    l1 = dbl(geo_a[15:0]) - ext(geo_a[47:32]);
    r1 = dbl(geo_a[15:0]) + ext(geo_a[47:32]);
    t1 = dbl(geo_a[31:16]) - ext(geo_a[63:48]);
    d1 = dbl(geo_a[31:16]) + ext(geo_a[63:48]);
    l2 = dbl(geo_b[15:0]) - ext(geo_b[47:32]);
    r2 = dbl(geo_b[15:0]) + ext(geo_b[47:32]);
    t2 = dbl(geo_b[31:16]) - ext(geo_b[63:48]);
    d2 = dbl(geo_b[31:16]) + ext(geo_b[63:48]);
    iw_s = ir_r - il_r;
    ih_s = id_r - it_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[IOU_LAT-2:0], start};
    end
    il_r     <= (l1 > l2) ? l1 : l2;
    ir_r     <= (r1 < r2) ? r1 : r2;
    it_r     <= (t1 > t2) ? t1 : t2;
    id_r     <= (d1 < d2) ? d1 : d2;
    aa_r     <= geo_a[47:32] * geo_a[63:48];
    ab_r     <= geo_b[47:32] * geo_b[63:48];
    ok_r     <= (il_r <= ir_r) && (it_r <= id_r);
    iw_r     <= iw_s[16:0];
    ih_r     <= ih_s[16:0];
    asum_r   <= {1'b0, aa_r} + {1'b0, ab_r};
    inter_r  <= iw_r * ih_r;
    asum2_r  <= asum_r;
    ok2_r    <= ok_r;
    uni_r    <= {asum2_r, 2'b00} - {1'b0, inter_r};
    inter3_r <= inter_r;
    ok3_r    <= ok2_r;
    prod_r   <= thr * uni_r;
    inter4_r <= inter3_r;
    ok4_r    <= ok3_r;
    hit_r    <= ok4_r && ({1'b0, inter4_r, 16'h0000} > prod_r);
  end

  assign res.done = vld_r[IOU_LAT-1];
  assign res.hit  = hit_r;

endmodule

// ===== rtl/per_class_greedy_box_suppression.sv =====
// Channel  Dir  Ports                          Contents (low bit up)
// in       in   in_tvalid/tready/tdata/tlast   cx,cy,box_width,box_height,score,class_index
//                                              tlast=final_box
// out      out  out_tvalid/tready/tdata/tlast  kept_cx,kept_cy,kept_width,kept_height,
//                /tuser                        kept_score,kept_class; tlast=end_of_list,
//                                              tuser=dropped_some
// cfg      in   cfg_wr_en/cfg_wr_data          iou_threshold
// Loading takes one beat per cycle. After the final beat the block stops taking input:
// it runs an insertion sort, one box at a time, shifting entries towards the tail as needed;
// suppression then skips each suppressed box, compares each kept box with the later boxes of
// its class (IoU pipeline), skips pairs already suppressed, and then closes the set.
// Reset is synchronous and needs no clearing pass. A stalled output holds the sequencer.
module per_class_greedy_box_suppression #(
  parameter int CAPACITY = pgbs_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pgbs_pkg::DATA_W-1:0] in_tdata,   // cx,cy,box_width,box_height,score,class_index
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pgbs_pkg::DATA_W-1:0] out_tdata,  // kept_cx,kept_cy,kept_width,kept_height,
                                                  // kept_score,kept_class
  output logic                        out_tlast,
  output logic                        out_tuser,  // dropped_some
  input  logic                        cfg_wr_en,
  input  logic [15:0]                 cfg_wr_data
);
  import pgbs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = KEY_W + AW;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  state_t state_r, state_nxt;
  logic [15:0] thr_r;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, jm1;
  logic ovf_r, ovf_nxt;
  logic [CAPACITY-1:0] marks_r, marks_nxt;
  logic [KEY_W-1:0] new_key_r, new_key_nxt, a_key_r, a_key_nxt;
  logic [AW-1:0] b_idx_r, b_idx_nxt;
  logic [GEO_W-1:0] a_geo_r, a_geo_nxt;
  logic pend_vld_r, pend_vld_nxt;
  logic [DATA_W-1:0] pend_r, pend_nxt;
  logic out_vld_r, out_vld_nxt, out_last_r, out_last_nxt, out_user_r, out_user_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  logic geo_we, sc_we, ord_we;
  logic [AW-1:0] geo_ra, sc_ra, ord_wa, ord_ra;
  logic [GEO_W-1:0] geo_rd;
  logic [KEY_W-1:0] sc_rd;
  logic [OW-1:0] ord_wd, ord_rd;
  logic iou_start, out_free;
  iou_res_t iou_res;

  pgbs_ram #(.WIDTH(GEO_W), .DEPTH(CAPACITY)) u_geo (
    .clk(clk), .wr_en(geo_we), .wr_addr(cnt_r[AW-1:0]), .wr_data(in_tdata[GEO_W-1:0]),
    .rd_addr(geo_ra), .rd_data(geo_rd)
  );

  pgbs_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_sc (
    .clk(clk), .wr_en(sc_we), .wr_addr(cnt_r[AW-1:0]),
    .wr_data(in_tdata[DATA_W-1:GEO_W]), .rd_addr(sc_ra), .rd_data(sc_rd)
  );

  pgbs_ram #(.WIDTH(OW), .DEPTH(CAPACITY)) u_ord (
    .clk(clk), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
    .rd_addr(ord_ra), .rd_data(ord_rd)
  );

  pgbs_iou u_iou (
    .clk(clk), .rst_n(rst_n), .start(iou_start), .geo_a(a_geo_r), .geo_b(geo_rd),
    .thr(thr_r), .res(iou_res)
  );

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;
  assign out_free   = !out_vld_r || out_tready;
  assign jm1        = j_r - ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      thr_r      <= THR_RESET;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      marks_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      marks_r    <= marks_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    new_key_r  <= new_key_nxt;
    a_key_r    <= a_key_nxt;
    b_idx_r    <= b_idx_nxt;
    a_geo_r    <= a_geo_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    marks_nxt    = marks_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    new_key_nxt  = new_key_r;
    a_key_nxt    = a_key_r;
    b_idx_nxt    = b_idx_r;
    a_geo_nxt    = a_geo_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_user_nxt = out_user_r;
    geo_we       = 1'b0;
    sc_we        = 1'b0;
    ord_we       = 1'b0;
    geo_ra       = '0;
    sc_ra        = i_r[AW-1:0];
    ord_ra       = '0;
    ord_wa       = j_r[AW-1:0];
    ord_wd       = {new_key_r, i_r[AW-1:0]};
    iou_start    = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CAP) begin
            geo_we  = 1'b1;
            sc_we   = 1'b1;
            cnt_nxt = cnt_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt     = '0;
            state_nxt = ST_SORT_START;
          end
        end
      end
      ST_SORT_START: begin
        if (i_r == cnt_r) begin
          i_nxt     = '0;
          state_nxt = ST_SUP_START;
        end else begin
          state_nxt = ST_SORT_NEW;
        end
      end
      ST_SORT_NEW: begin
        new_key_nxt = sc_rd;
        j_nxt       = i_r;
        state_nxt   = ST_SORT_STEP;
      end
      ST_SORT_STEP: begin
        if (j_r == '0) begin
          ord_we    = 1'b1;
          i_nxt     = i_r + ONE;
          state_nxt = ST_SORT_START;
        end else begin
          ord_ra    = jm1[AW-1:0];
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        ord_we = 1'b1;
        if (ranks_before(new_key_r, ord_rd[OW-1:AW])) begin
          ord_wd    = ord_rd;
          j_nxt     = jm1;
          state_nxt = ST_SORT_STEP;
        end else begin
          i_nxt     = i_r + ONE;
          state_nxt = ST_SORT_START;
        end
      end
      ST_SUP_START: begin
        ord_ra = i_r[AW-1:0];
        if (i_r == cnt_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_SUP_A;
        end
      end
      ST_SUP_A: begin
        if (marks_r[ord_rd[AW-1:0]]) begin
          i_nxt     = i_r + ONE;
          state_nxt = ST_SUP_START;
        end else begin
          a_key_nxt = ord_rd[OW-1:AW];
          geo_ra    = ord_rd[AW-1:0];
          k_nxt     = i_r + ONE;
          state_nxt = ST_SUP_AG;
        end
      end
      ST_SUP_AG: begin
        a_geo_nxt = geo_rd;
        state_nxt = ST_SUP_K;
      end
      ST_SUP_K: begin
        ord_ra = k_r[AW-1:0];
        if (k_r == cnt_r) begin
          state_nxt = ST_SUP_KEEP;
        end else begin
          state_nxt = ST_SUP_B;
        end
      end
      ST_SUP_B: begin
        if (ord_rd[OW-1:AW+SCORE_W] != a_key_r[KEY_W-1:SCORE_W]) begin
          state_nxt = ST_SUP_KEEP;
        end else if (marks_r[ord_rd[AW-1:0]]) begin
          k_nxt     = k_r + ONE;
          state_nxt = ST_SUP_K;
        end else begin
          b_idx_nxt = ord_rd[AW-1:0];
          geo_ra    = ord_rd[AW-1:0];
          state_nxt = ST_SUP_BG;
        end
      end
      ST_SUP_BG: begin
        iou_start = 1'b1;
        state_nxt = ST_SUP_WAIT;
      end
      ST_SUP_WAIT: begin
        if (iou_res.done) begin
          if (iou_res.hit) begin
            marks_nxt[b_idx_r] = 1'b1;
          end
          k_nxt     = k_r + ONE;
          state_nxt = ST_SUP_K;
        end
      end
      ST_SUP_KEEP: begin
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_data_nxt = pend_r;
            out_last_nxt = 1'b0;
            out_user_nxt = ovf_r;
          end
          pend_vld_nxt = 1'b1;
          pend_nxt     = {a_key_r, a_geo_r};
          i_nxt        = i_r + ONE;
          state_nxt    = ST_SUP_START;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = pend_r;
          out_last_nxt = 1'b1;
          out_user_nxt = ovf_r;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          ovf_nxt      = 1'b0;
          marks_nxt    = '0;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/pgbs_chk.sv =====
module pgbs_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tlast,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken after final beat");

  a_load_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("loading stopped before final beat");

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tlast))
    else $error("end of list changed while stalled");

endmodule

bind per_class_greedy_box_suppression pgbs_chk u_pgbs_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tlast(out_tlast)
);

// ===== dv/tb_per_class_greedy_box_suppression.sv =====
module tb_per_class_greedy_box_suppression;
  timeunit 1ns;
  timeprecision 1ps;
  import pgbs_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int SET_GAP = 40;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    logic [CRD_W-1:0]   h;
    logic [CRD_W-1:0]   w;
    logic [CRD_W-1:0]   cy;
    logic [CRD_W-1:0]   cx;
  } box_t;

  typedef struct packed {
    box_t bx;
    logic eol;
    logic dropped;
  } kept_t;

  typedef struct {
    box_t bx;
    logic fin;
    logic chk;
    kept_t want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = '0;

  per_class_greedy_box_suppression u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [15:0] thr;
  box_t held[$];
  logic spilled;
  kept_t kept_q[$];
  kept_t pinned_q[$];
  int errors = 0;
  int n_boxes = 0, n_kept = 0, n_sets = 0;
  longint cyc = 0;
  bit stall_on = 0;

  function automatic bit iou_hit(box_t a, box_t b);
    longint l1, r1, t1, d1, l2, r2, t2, d2, il, ir, it, id;
    longint unsigned inter, uni;
    l1 = 2*longint'(a.cx) - a.w; r1 = 2*longint'(a.cx) + a.w;
    t1 = 2*longint'(a.cy) - a.h; d1 = 2*longint'(a.cy) + a.h;
    l2 = 2*longint'(b.cx) - b.w; r2 = 2*longint'(b.cx) + b.w;
    t2 = 2*longint'(b.cy) - b.h; d2 = 2*longint'(b.cy) + b.h;
    il = l1 > l2 ? l1 : l2; ir = r1 < r2 ? r1 : r2;
    it = t1 > t2 ? t1 : t2; id = d1 < d2 ? d1 : d2;
    if (il > ir || it > id) return 0;
    inter = longint'(ir - il) * longint'(id - it);
    uni = 4*(longint'(a.w)*a.h) + 4*(longint'(b.w)*b.h) - inter;
    return inter * 65536 > longint'(thr) * uni;
  endfunction

  function automatic bit goes_first(box_t x, box_t y);
    if (x.cls != y.cls) return x.cls < y.cls;
    return x.score > y.score;
  endfunction

  task automatic absorb_box(box_t bx, logic fin);
    int order[$];
    bit gone[CAP];
    int j, a, b, first;
    kept_t kv;
    if (held.size() < CAP) held.insert(held.size(), bx);
    else spilled = 1;
    if (!fin) return;
    for (int i = 0; i < held.size(); i++) begin
      j = order.size();
      while (j > 0 && goes_first(held[i], held[order[j-1]])) j--;
      order.insert(j, i);
      gone[i] = 0;
    end
    first = kept_q.size();
    for (int i = 0; i < order.size(); i++) begin
      a = order[i];
      if (gone[a]) continue;
      for (int k = i + 1; k < order.size(); k++) begin
        b = order[k];
        if (held[b].cls != held[a].cls) break;
        if (!gone[b] && iou_hit(held[a], held[b])) gone[b] = 1;
      end
      kv.bx = held[a];
      kv.eol = 0;
      kv.dropped = spilled;
      kept_q.insert(kept_q.size(), kv);
    end
    kept_q[kept_q.size()-1].eol = 1;
    n_sets++;
    held.delete();
    spilled = 0;
  endtask

  always @(posedge clk) begin
    kept_t got, exp;
    cyc <= cyc + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{bx: box_t'(out_tdata), eol: out_tlast, dropped: out_tuser};
      n_kept++;
      if (kept_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", got);
      end else begin
        exp = kept_q.pop_front();
        if (got !== exp) begin
          errors++;
          if (errors <= 10) $display("beat mismatch: exp %h got %h", exp, got);
        end
      end
    end
    if ($urandom_range(0, 199) == 0) stall_on <= !stall_on;
    out_tready <= stall_on ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
  end

  always @(posedge clk) begin
    if (cyc > LIMIT) begin
      $display("timeout at cycle %0d", cyc);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_box(box_t bx, logic fin);
    in_tvalid <= 1;
    in_tdata <= DATA_W'(bx);
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_box(bx, fin);
    n_boxes++;
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_then_cfg(logic [15:0] v);
    in_tvalid <= 0;
    while (kept_q.size() > 0) @(posedge clk);
    repeat (SET_GAP) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    thr = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic box_t rand_box(int cls_max, int spread);
    box_t bx;
    bx.cx = 16'($urandom_range(400, 400 + spread));
    bx.cy = 16'($urandom_range(400, 400 + spread));
    bx.w = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400));
    bx.h = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400));
    if ($urandom_range(0, 9) == 0) begin bx.cx = 16'($urandom); bx.cy = 16'($urandom); end
    bx.score = $urandom_range(0, 2) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom);
    bx.cls = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, cls_max));
    return bx;
  endfunction

  row_t rows[$];

  task automatic add_row(box_t bx, logic fin, logic chk, kept_t want);
    row_t r;
    r.bx = bx;
    r.fin = fin;
    r.chk = chk;
    r.want = want;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    box_t b;
    int n;
    thr = THR_RESET;
    spilled = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single box: kept as is, end of list
    b = '{cls: 8'hFF, score: 16'hFFFF, h: 16'hFFFF, w: 16'hFFFF, cy: 16'hFFFF, cx: 16'hFFFF};
    add_row(b, 1, 1, {b, 1'b1, 1'b0});
    b = '0;
    add_row(b, 1, 1, {b, 1'b1, 1'b0});
    // identical boxes: second suppressed; zero-area pair survives
    b = '{cls: 3, score: 100, h: 64, w: 64, cy: 800, cx: 800};
    add_row(b, 0, 0, '0);
    add_row(b, 0, 0, '0);
    b = '{cls: 3, score: 50, h: 0, w: 0, cy: 800, cx: 800};
    add_row(b, 0, 0, '0);
    add_row(b, 0, 0, '0);
    // touching edges
    b = '{cls: 1, score: 7, h: 32, w: 32, cy: 100, cx: 100};
    add_row(b, 0, 0, '0);
    b = '{cls: 1, score: 7, h: 32, w: 32, cy: 100, cx: 132};
    add_row(b, 0, 0, '0);
    b = '{cls: 0, score: 7, h: 32, w: 32, cy: 100, cx: 100};
    add_row(b, 0, 0, '0);
    b = '{cls: 1, score: 9, h: 40, w: 30, cy: 110, cx: 105};
    add_row(b, 1, 0, '0);
    foreach (rows[i]) begin
      if (rows[i].chk) pinned_q.insert(pinned_q.size(), rows[i].want);
      send_box(rows[i].bx, rows[i].fin);
      if (rows[i].chk) begin
        if (kept_q[kept_q.size()-1] !== pinned_q.pop_front()) begin
          errors++;
          if (errors <= 10) $display("directed row %0d predicts wrongly", i);
        end
      end
    end

    // overflow: capacity plus extras, final discarded
    drain_then_cfg(16'hFFFF);
    for (int i = 0; i < CAP + 3; i++) send_box(rand_box(2, 200), i == CAP + 2);
    drain_then_cfg(16'h0000);
    for (int i = 0; i < 12; i++) send_box(rand_box(2, 100), i == 11);

    for (int ph = 0; ph < 4; ph++) begin
      drain_then_cfg(ph == 0 ? THR_RESET : 16'($urandom));
      for (int s = 0; s < 20; s++) begin
        n = $urandom_range(0, 19) == 0 ? $urandom_range(20, CAP) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_box(rand_box(3, 150), i == n - 1);
      end
    end

    in_tvalid <= 0;
    while (kept_q.size() > 0) @(posedge clk);
    repeat (SET_GAP) @(posedge clk);
    $display("%0d boxes in %0d sets, %0d kept boxes checked", n_boxes, n_sets, n_kept);
    $display("thresholds 0, max, reset and random; overflow and tie cases included");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== per_class_greedy_box_suppression.f =====
rtl/pgbs_pkg.sv
rtl/pgbs_ram.sv
rtl/pgbs_iou.sv
rtl/per_class_greedy_box_suppression.sv
rtl/pgbs_chk.sv
dv/tb_per_class_greedy_box_suppression.sv
